### hdl/gda_pkg.sv
// Shared types, widths, constants and calendar tables for the Gregorian date unit.
// No dependencies.
package gda_pkg;

  localparam int MAX_YEAR = 9999;
  localparam int YEAR_W   = 14;
  localparam int MON_W    = 4;
  localparam int DOM_W    = 5;
  localparam int CNT_W    = 22;
  localparam int SER_W    = CNT_W + 1;
  localparam int STEP_W   = 5;
  localparam int MONTHS   = 12;

  // Serial day number of the last day of MAX_YEAR, counted from 0001-01-01.
  localparam int TOP_SERIAL = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400 - 1;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_SUB,
    REQ_DIFF,
    REQ_NONE
  } req_e;

  typedef enum logic [1:0] {
    STG_400,
    STG_100,
    STG_4,
    STG_1
  } stage_e;

  function automatic logic [SER_W-1:0] day_stride(input stage_e stg);
    logic [SER_W-1:0] r;
    case (stg)
      STG_400: r = SER_W'(146097);
      STG_100: r = SER_W'(36524);
      STG_4:   r = SER_W'(1461);
      default: r = SER_W'(365);
    endcase
    return r;
  endfunction

  function automatic logic [SER_W-1:0] year_stride(input stage_e stg);
    logic [SER_W-1:0] r;
    case (stg)
      STG_400: r = SER_W'(400);
      STG_100: r = SER_W'(100);
      STG_4:   r = SER_W'(4);
      default: r = SER_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [DOM_W-1:0] month_len(input logic leap, input logic [MON_W-1:0] mo);
    logic [DOM_W-1:0] r;
    case (mo)
      4'd2:                      r = leap ? DOM_W'(29) : DOM_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   r = DOM_W'(30);
      default:                   r = DOM_W'(31);
    endcase
    return r;
  endfunction

endpackage

### hdl/gda_stride_unit.sv
// Shared arithmetic unit of the date sequencer: one subtract with borrow and one add.
// Depends on gda_pkg.
module gda_stride_unit (
  input  logic [gda_pkg::SER_W-1:0] res_i,
  input  logic [gda_pkg::SER_W-1:0] res_stride_i,
  input  logic [gda_pkg::SER_W-1:0] acc_i,
  input  logic [gda_pkg::SER_W-1:0] acc_stride_i,
  output logic [gda_pkg::SER_W-1:0] diff_o,
  output logic                      borrow_o,
  output logic [gda_pkg::SER_W-1:0] sum_o
);

  logic [gda_pkg::SER_W:0] sub_full;

  assign sub_full = {1'b0, res_i} - {1'b0, res_stride_i};
  assign diff_o   = sub_full[gda_pkg::SER_W-1:0];
  assign borrow_o = sub_full[gda_pkg::SER_W];
  assign sum_o    = acc_i + acc_stride_i;

endmodule

### hdl/gregorian_date_arithmetic_top.sv
// Gregorian date unit: add days, subtract days, or day distance between two dates.
// Depends on gda_pkg and gda_stride_unit.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one request word: req_type_i, the first
//   date, the second date (difference only) and day_count_i (add and subtract only).
//   Output channel out_valid_o/out_ready_i carries one result word per request.
//   Each date is turned into a serial day number by stepping 400-, 100-, 4- and 1-year
//   strides and then months through one shared add/subtract unit; a date result is
//   turned back the same way. One step per cycle.
//   The number of steps for a request is set by the stride counts of the year and month
//   of each date and of a date result; an invalid date skips its strides.
//   One request is in work at a time; in_ready_o is high only while the sequencer idles,
//   so a new request is taken only once the previous one has left the sequencer.
//   A finished result sits in the output register; the next request is taken while it
//   waits. If the receiver stalls and the output register is still full when a second
//   result is done, the sequencer holds that result until the register empties.
//   Reset clears the sequencer and drops any pending result; no clearing pass is needed.
module gregorian_date_arithmetic_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [gda_pkg::YEAR_W-1:0]  year_i,
  input  logic [gda_pkg::MON_W-1:0]   month_i,
  input  logic [gda_pkg::DOM_W-1:0]   day_i,
  input  logic [gda_pkg::YEAR_W-1:0]  other_year_i,
  input  logic [gda_pkg::MON_W-1:0]   other_month_i,
  input  logic [gda_pkg::DOM_W-1:0]   other_day_i,
  input  logic [gda_pkg::CNT_W-1:0]   day_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gda_pkg::YEAR_W-1:0]  res_year_o,
  output logic [gda_pkg::MON_W-1:0]   res_month_o,
  output logic [gda_pkg::DOM_W-1:0]   res_day_o,
  output logic [gda_pkg::CNT_W-1:0]   days_between_o,
  output logic                        input_fixed_o,
  output logic                        range_error_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DATE,
    ST_SYEAR,
    ST_SMON,
    ST_SDAY,
    ST_OP,
    ST_DIFF,
    ST_UYEAR,
    ST_UMON,
    ST_FINISH
  } state_e;

  state_e                         state_q;
  gda_pkg::req_e                  req_q;
  gda_pkg::stage_e                stage_q;
  logic [gda_pkg::YEAR_W-1:0]     y_q, oy_q;
  logic [gda_pkg::MON_W-1:0]      m_q, om_q;
  logic [gda_pkg::DOM_W-1:0]      d_q, od_q;
  logic [gda_pkg::CNT_W-1:0]      cnt_q;
  logic                           sel_q;
  logic [gda_pkg::SER_W-1:0]      res_q, acc_q;
  logic [gda_pkg::STEP_W-1:0]     step_q;
  logic [1:0]                     c100_q, c1_q;
  logic [gda_pkg::STEP_W-1:0]     c4_q;
  logic [gda_pkg::MON_W-1:0]      mo_q;
  logic [gda_pkg::CNT_W-1:0]      a_q, b_q;
  logic [gda_pkg::YEAR_W-1:0]     ry_q;
  logic [gda_pkg::MON_W-1:0]      rm_q;
  logic [gda_pkg::DOM_W-1:0]      rd_q;
  logic [gda_pkg::CNT_W-1:0]      dist_q;
  logic                           fixed_q, err_q;
  logic                           ovalid_q;
  logic [gda_pkg::YEAR_W-1:0]     oy_out_q;
  logic [gda_pkg::MON_W-1:0]      om_out_q;
  logic [gda_pkg::DOM_W-1:0]      od_out_q;
  logic [gda_pkg::CNT_W-1:0]      dist_out_q;
  logic                           fixed_out_q, err_out_q;

  logic [gda_pkg::SER_W-1:0]      u_res, u_rs, u_acc, u_as, u_diff, u_sum;
  logic                           u_borrow;
  logic [gda_pkg::YEAR_W-1:0]     cur_y;
  logic [gda_pkg::MON_W-1:0]      cur_m;
  logic [gda_pkg::DOM_W-1:0]      cur_d;
  logic                           leap;
  logic                           date_bad;
  logic                           day_bad;
  logic                           stage_cap;
  logic                           out_free;
  logic                           more_dates;

  assign cur_y = sel_q ? oy_q : y_q;
  assign cur_m = sel_q ? om_q : m_q;
  assign cur_d = sel_q ? od_q : d_q;

  assign leap      = (c1_q == 2'd3) && !((c4_q == gda_pkg::STEP_W'(24)) && (c100_q != 2'd3));
  assign date_bad  = (cur_y == '0) || (cur_y > gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR)) ||
                     (cur_m == '0) || (cur_m > gda_pkg::MON_W'(gda_pkg::MONTHS)) ||
                     (cur_d == '0);
  assign day_bad   = cur_d > gda_pkg::month_len(leap, cur_m);
  assign stage_cap = ((stage_q == gda_pkg::STG_100) || (stage_q == gda_pkg::STG_1)) &&
                     (step_q == gda_pkg::STEP_W'(3));
  assign out_free   = !ovalid_q || out_ready_i;
  assign more_dates = (req_q == gda_pkg::REQ_DIFF) && !sel_q;

  always_comb begin
    u_res = res_q;
    u_rs  = '0;
    u_acc = acc_q;
    u_as  = '0;
    case (state_q)
      ST_SYEAR: begin
        u_rs = gda_pkg::year_stride(stage_q);
        u_as = gda_pkg::day_stride(stage_q);
      end
      ST_UYEAR: begin
        u_rs = gda_pkg::day_stride(stage_q);
        u_as = gda_pkg::year_stride(stage_q);
      end
      ST_SMON: begin
        u_as = gda_pkg::SER_W'(gda_pkg::month_len(leap, mo_q));
      end
      ST_SDAY: begin
        u_as = gda_pkg::SER_W'(cur_d - gda_pkg::DOM_W'(1));
      end
      ST_UMON: begin
        u_rs = gda_pkg::SER_W'(gda_pkg::month_len(leap, mo_q));
      end
      ST_OP: begin
        u_res = gda_pkg::SER_W'(a_q);
        u_rs  = (req_q == gda_pkg::REQ_DIFF) ? gda_pkg::SER_W'(b_q) : gda_pkg::SER_W'(cnt_q);
        u_acc = gda_pkg::SER_W'(a_q);
        u_as  = gda_pkg::SER_W'(cnt_q);
      end
      ST_DIFF: begin
        u_res = gda_pkg::SER_W'(b_q);
        u_rs  = gda_pkg::SER_W'(a_q);
      end
      default: begin
        u_res = res_q;
      end
    endcase
  end

  gda_stride_unit u_stride (
    .res_i        (u_res),
    .res_stride_i (u_rs),
    .acc_i        (u_acc),
    .acc_stride_i (u_as),
    .diff_o       (u_diff),
    .borrow_o     (u_borrow),
    .sum_o        (u_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= gda_pkg::REQ_ADD;
      stage_q     <= gda_pkg::STG_400;
      y_q         <= '0;
      m_q         <= '0;
      d_q         <= '0;
      oy_q        <= '0;
      om_q        <= '0;
      od_q        <= '0;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
      res_q       <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      c100_q      <= '0;
      c4_q        <= '0;
      c1_q        <= '0;
      mo_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      ry_q        <= '0;
      rm_q        <= '0;
      rd_q        <= '0;
      dist_q      <= '0;
      fixed_q     <= 1'b0;
      err_q       <= 1'b0;
      ovalid_q    <= 1'b0;
      oy_out_q    <= '0;
      om_out_q    <= '0;
      od_out_q    <= '0;
      dist_out_q  <= '0;
      fixed_out_q <= 1'b0;
      err_out_q   <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i && (state_q != ST_FINISH)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q   <= gda_pkg::req_e'(req_type_i);
            y_q     <= year_i;
            m_q     <= month_i;
            d_q     <= day_i;
            oy_q    <= other_year_i;
            om_q    <= other_month_i;
            od_q    <= other_day_i;
            cnt_q   <= day_count_i;
            sel_q   <= 1'b0;
            fixed_q <= 1'b0;
            err_q   <= 1'b0;
            dist_q  <= '0;
            state_q <= ST_DATE;
          end
        end
        ST_DATE: begin
          if (date_bad) begin
            fixed_q <= 1'b1;
            if (sel_q) begin
              b_q <= '0;
            end else begin
              a_q <= '0;
            end
            if (more_dates) begin
              sel_q   <= 1'b1;
              state_q <= ST_DATE;
            end else begin
              state_q <= ST_OP;
            end
          end else begin
            res_q   <= gda_pkg::SER_W'(cur_y - gda_pkg::YEAR_W'(1));
            acc_q   <= '0;
            stage_q <= gda_pkg::STG_400;
            step_q  <= '0;
            state_q <= ST_SYEAR;
          end
        end
        ST_SYEAR, ST_UYEAR: begin
          if (u_borrow || stage_cap) begin
            case (stage_q)
              gda_pkg::STG_100: c100_q <= step_q[1:0];
              gda_pkg::STG_4:   c4_q   <= step_q;
              gda_pkg::STG_1:   c1_q   <= step_q[1:0];
              default:          c100_q <= c100_q;
            endcase
            step_q <= '0;
            if (stage_q == gda_pkg::STG_1) begin
              mo_q    <= gda_pkg::MON_W'(1);
              state_q <= (state_q == ST_SYEAR) ? ST_SMON : ST_UMON;
            end else begin
              stage_q <= gda_pkg::stage_e'(stage_q + 2'd1);
            end
          end else begin
            res_q  <= u_diff;
            acc_q  <= u_sum;
            step_q <= step_q + gda_pkg::STEP_W'(1);
          end
        end
        ST_SMON: begin
          if (mo_q == cur_m) begin
            state_q <= ST_SDAY;
          end else begin
            acc_q <= u_sum;
            mo_q  <= mo_q + gda_pkg::MON_W'(1);
          end
        end
        ST_SDAY: begin
          if (day_bad) begin
            fixed_q <= 1'b1;
          end
          if (sel_q) begin
            b_q <= day_bad ? '0 : u_sum[gda_pkg::CNT_W-1:0];
          end else begin
            a_q <= day_bad ? '0 : u_sum[gda_pkg::CNT_W-1:0];
          end
          if (more_dates) begin
            sel_q   <= 1'b1;
            state_q <= ST_DATE;
          end else begin
            state_q <= ST_OP;
          end
        end
        ST_OP: begin
          acc_q   <= '0;
          stage_q <= gda_pkg::STG_400;
          step_q  <= '0;
          case (req_q)
            gda_pkg::REQ_ADD: begin
              if (u_sum > gda_pkg::SER_W'(gda_pkg::TOP_SERIAL)) begin
                res_q <= gda_pkg::SER_W'(gda_pkg::TOP_SERIAL);
                err_q <= 1'b1;
              end else begin
                res_q <= u_sum;
              end
              state_q <= ST_UYEAR;
            end
            gda_pkg::REQ_SUB: begin
              if (u_borrow) begin
                res_q <= '0;
                err_q <= 1'b1;
              end else begin
                res_q <= u_diff;
              end
              state_q <= ST_UYEAR;
            end
            gda_pkg::REQ_DIFF: begin
              ry_q <= gda_pkg::YEAR_W'(1);
              rm_q <= gda_pkg::MON_W'(1);
              rd_q <= gda_pkg::DOM_W'(1);
              if (u_borrow) begin
                state_q <= ST_DIFF;
              end else begin
                dist_q  <= u_diff[gda_pkg::CNT_W-1:0];
                state_q <= ST_FINISH;
              end
            end
            default: begin
              res_q   <= gda_pkg::SER_W'(a_q);
              state_q <= ST_UYEAR;
            end
          endcase
        end
        ST_DIFF: begin
          dist_q  <= u_diff[gda_pkg::CNT_W-1:0];
          state_q <= ST_FINISH;
        end
        ST_UMON: begin
          if ((mo_q == gda_pkg::MON_W'(gda_pkg::MONTHS)) || u_borrow) begin
            ry_q    <= gda_pkg::YEAR_W'(acc_q) + gda_pkg::YEAR_W'(1);
            rm_q    <= mo_q;
            rd_q    <= gda_pkg::DOM_W'(res_q) + gda_pkg::DOM_W'(1);
            state_q <= ST_FINISH;
          end else begin
            res_q <= u_diff;
            mo_q  <= mo_q + gda_pkg::MON_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            ovalid_q    <= 1'b1;
            oy_out_q    <= ry_q;
            om_out_q    <= rm_q;
            od_out_q    <= rd_q;
            dist_out_q  <= dist_q;
            fixed_out_q <= fixed_q;
            err_out_q   <= err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = ovalid_q;
  assign res_year_o     = oy_out_q;
  assign res_month_o    = om_out_q;
  assign res_day_o      = od_out_q;
  assign days_between_o = dist_out_q;
  assign input_fixed_o  = fixed_out_q;
  assign range_error_o  = err_out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while sequencer busy");

  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_year_o >= gda_pkg::YEAR_W'(1)) &&
                    (res_year_o <= gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR)))
    else $error("result year out of range");

  a_date_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_month_o >= gda_pkg::MON_W'(1)) &&
                    (res_month_o <= gda_pkg::MON_W'(gda_pkg::MONTHS)) &&
                    (res_day_o >= gda_pkg::DOM_W'(1)) &&
                    (res_day_o <= gda_pkg::month_len(1'b1, res_month_o)))
    else $error("result date not a calendar date");

  a_dist_date_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (days_between_o != '0)) |->
      (res_year_o == gda_pkg::YEAR_W'(1)) && (res_month_o == gda_pkg::MON_W'(1)) &&
      (res_day_o == gda_pkg::DOM_W'(1)) && !range_error_o)
    else $error("difference word with a date result");
`endif

endmodule
